// ===== sv/midpoint_line_rasterizer_macros.svh =====
// Assertion macros shared by the line rasterizer RTL.
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked while out of reset.
`define MLR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define MLR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define MLR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MLR_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/mlr_pkg.sv =====
// Shared types and constants for the midpoint line rasterizer.
package mlr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 24;

  // Item kinds on the input channel.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Octant cases of the midpoint walk.
  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,  // drive x, y may go up
    OCT_STEEP_UP     = 2'd1,  // drive y up, x may go up
    OCT_STEEP_DOWN   = 2'd2,  // drive y down, x may go up
    OCT_SHALLOW_DOWN = 2'd3   // drive x, y may go down
  } oct_t;

endpackage

// ===== sv/mlr_setup.sv =====
// Line setup: endpoint ordering, step terms, octant and initial decision value.
module mlr_setup #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  output mlr_pkg::oct_t                oct_o,
  output logic signed [COORD_BITS+3:0] dec_o,
  output logic signed [COORD_BITS+1:0] step_a_o,
  output logic signed [COORD_BITS+1:0] step_b_o,
  output logic signed [COORD_BITS-1:0] stop_o,
  output logic signed [COORD_BITS-1:0] start_x_o,
  output logic signed [COORD_BITS-1:0] start_y_o
);
  import mlr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SW = COORD_BITS + 2;
  localparam int DW = COORD_BITS + 4;

  logic                 swap;
  logic signed [CW-1:0] xs, ys, xe, ye;
  logic signed [CW:0]   dx, dy;
  logic signed [SW-1:0] a, b;
  logic signed [DW-1:0] a_ext, b_ext, a_half, b_half, neg_b;

  assign swap = (x0_i > x1_i);
  assign xs   = swap ? x1_i : x0_i;
  assign ys   = swap ? y1_i : y0_i;
  assign xe   = swap ? x0_i : x1_i;
  assign ye   = swap ? y0_i : y1_i;

  assign dx = (CW+1)'(xe) - (CW+1)'(xs);
  assign dy = (CW+1)'(ye) - (CW+1)'(ys);

  assign a = {dy, 1'b0};
  assign b = SW'(0) - {dx, 1'b0};

  // Both step terms are even, so the halves are exact.
  assign a_ext  = DW'(a);
  assign b_ext  = DW'(b);
  assign a_half = DW'(dy);
  assign b_half = DW'(b >>> 1);
  assign neg_b  = DW'(0) - b_ext;

  always_comb begin
    if (!a[SW-1] && (a_ext <= neg_b)) begin
      oct_o  = OCT_SHALLOW_UP;
      dec_o  = a_ext + b_half;
      stop_o = xe;
    end else if (!a[SW-1]) begin
      oct_o  = OCT_STEEP_UP;
      dec_o  = a_half + b_ext;
      stop_o = ye;
    end else if (a_ext <= b_ext) begin
      oct_o  = OCT_STEEP_DOWN;
      dec_o  = a_half - b_ext;
      stop_o = ye;
    end else begin
      oct_o  = OCT_SHALLOW_DOWN;
      dec_o  = a_ext - b_half;
      stop_o = xe;
    end
  end

  assign step_a_o  = a;
  assign step_b_o  = b;
  assign start_x_o = xs;
  assign start_y_o = ys;

endmodule

// ===== sv/midpoint_line_rasterizer.sv =====
// Midpoint line rasterizer top level: input, setup and walk/output stages.
//
//  channel | dir | tdata (low bit up)                           | tuser | tlast
//  in_*    | in  | start_x, start_y, end_x, end_y, pen_color,   | cmd   | -
//          |     | coord_mode, zero fill to bytes               |       |
//  out_*   | out | pixel_x, pixel_y, pixel_color, pixel_mode,   | -     | last_pixel
//          |     | zero fill to bytes                           |       |
//
//  One item per clock sustained while out_tready does not stall the output.
//  Three registers deep: input register, setup register (ordering, step terms, octant,
//  initial decision), then the walk step into the output register. Line state lives in
//  the walk step only, so back-to-back steps see each other's results.
//  rst_n is synchronous; it clears the stage valids and the line-active flag.
//  A stalled output holds the whole pipe (in_tready follows the output slot).
module midpoint_line_rasterizer #(
  parameter  int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + mlr_pkg::COLOR_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + mlr_pkg::COLOR_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // start_x, start_y, end_x, end_y, pen_color, coord_mode, zero fill
  input  logic [IN_W-1:0]  in_tdata,
  // cmd
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pixel_x, pixel_y, pixel_color, pixel_mode, zero fill
  output logic [OUT_W-1:0] out_tdata,
  // last_pixel
  output logic             out_tlast
);
  import mlr_pkg::*;

  `include "midpoint_line_rasterizer_macros.svh"

  localparam int CW = COORD_BITS;
  localparam int SW = COORD_BITS + 2;
  localparam int DW = COORD_BITS + 4;
  localparam int KW = COLOR_BITS;
  localparam logic signed [CW-1:0] ONE = CW'(1);

  // Whole pipe advances when the output slot is free or being drained.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- stage 1: input register ----------------
  logic                 s1_vld_r;
  logic                 s1_cmd_r;
  logic signed [CW-1:0] s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r;
  logic [KW-1:0]        s1_color_r;
  logic                 s1_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r   <= in_tuser;
      s1_x0_r    <= in_tdata[CW-1:0];
      s1_y0_r    <= in_tdata[2*CW-1:CW];
      s1_x1_r    <= in_tdata[3*CW-1:2*CW];
      s1_y1_r    <= in_tdata[4*CW-1:3*CW];
      s1_color_r <= in_tdata[4*CW+KW-1:4*CW];
      s1_mode_r  <= in_tdata[4*CW+KW];
    end
  end

  // ---------------- stage 2: line setup ----------------
  oct_t                 su_oct;
  logic signed [DW-1:0] su_dec;
  logic signed [SW-1:0] su_a, su_b;
  logic signed [CW-1:0] su_stop, su_x, su_y;

  mlr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x0_i      (s1_x0_r),
    .y0_i      (s1_y0_r),
    .x1_i      (s1_x1_r),
    .y1_i      (s1_y1_r),
    .oct_o     (su_oct),
    .dec_o     (su_dec),
    .step_a_o  (su_a),
    .step_b_o  (su_b),
    .stop_o    (su_stop),
    .start_x_o (su_x),
    .start_y_o (su_y)
  );

  logic                 s2_vld_r;
  logic                 s2_cmd_r;
  oct_t                 s2_oct_r;
  logic signed [DW-1:0] s2_dec_r;
  logic signed [SW-1:0] s2_a_r, s2_b_r;
  logic signed [CW-1:0] s2_stop_r, s2_x_r, s2_y_r;
  logic [KW-1:0]        s2_color_r;
  logic                 s2_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_oct_r   <= su_oct;
      s2_dec_r   <= su_dec;
      s2_a_r     <= su_a;
      s2_b_r     <= su_b;
      s2_stop_r  <= su_stop;
      s2_x_r     <= su_x;
      s2_y_r     <= su_y;
      s2_color_r <= s1_color_r;
      s2_mode_r  <= s1_mode_r;
    end
  end

  // ---------------- line state ----------------
  logic signed [CW-1:0] cur_x_r, cur_y_r, stop_r;
  logic signed [DW-1:0] dec_r;
  logic signed [SW-1:0] a_r, b_r;
  oct_t                 oct_r;
  logic                 active_r;
  logic [KW-1:0]        color_r;
  logic                 mode_r;

  // ---------------- stage 3: walk step ----------------
  // A start item replaces the loaded line before its first pixel goes out.
  logic                 is_start;
  logic signed [CW-1:0] eff_x, eff_y, eff_stop, drive;
  logic signed [DW-1:0] eff_dec, a_ext, b_ext;
  oct_t                 eff_oct;
  logic [KW-1:0]        eff_color;
  logic                 eff_mode;
  logic                 eff_active;
  logic                 emit;
  logic                 last;
  logic                 dec_pos, dec_neg;

  logic signed [CW-1:0] adv_x, adv_y;
  logic signed [DW-1:0] adv_dec;

  logic signed [CW-1:0] cur_x_nxt, cur_y_nxt, stop_nxt;
  logic signed [DW-1:0] dec_nxt;
  logic signed [SW-1:0] a_nxt, b_nxt;
  oct_t                 oct_nxt;
  logic                 active_nxt;
  logic [KW-1:0]        color_nxt;
  logic                 mode_nxt;

  assign is_start   = (s2_cmd_r == CMD_START);
  assign eff_x      = is_start ? s2_x_r     : cur_x_r;
  assign eff_y      = is_start ? s2_y_r     : cur_y_r;
  assign eff_stop   = is_start ? s2_stop_r  : stop_r;
  assign eff_dec    = is_start ? s2_dec_r   : dec_r;
  assign eff_oct    = is_start ? s2_oct_r   : oct_r;
  assign eff_color  = is_start ? s2_color_r : color_r;
  assign eff_mode   = is_start ? s2_mode_r  : mode_r;
  assign eff_active = is_start || active_r;
  assign a_ext      = DW'(is_start ? s2_a_r : a_r);
  assign b_ext      = DW'(is_start ? s2_b_r : b_r);

  assign emit  = s2_vld_r && eff_active;
  assign drive = (eff_oct == OCT_STEEP_UP || eff_oct == OCT_STEEP_DOWN) ? eff_y : eff_x;
  assign last  = (drive == eff_stop);

  assign dec_pos = !eff_dec[DW-1] && (|eff_dec);
  assign dec_neg = eff_dec[DW-1];

  // Ties leave the minor coordinate alone in every octant.
  always_comb begin
    adv_x   = eff_x;
    adv_y   = eff_y;
    adv_dec = eff_dec;
    case (eff_oct)
      OCT_SHALLOW_UP: begin
        adv_x   = eff_x + ONE;
        adv_y   = dec_pos ? eff_y + ONE : eff_y;
        adv_dec = eff_dec + a_ext + (dec_pos ? b_ext : DW'(0));
      end
      OCT_STEEP_UP: begin
        adv_x   = dec_neg ? eff_x + ONE : eff_x;
        adv_y   = eff_y + ONE;
        adv_dec = eff_dec + b_ext + (dec_neg ? a_ext : DW'(0));
      end
      OCT_STEEP_DOWN: begin
        adv_x   = dec_pos ? eff_x + ONE : eff_x;
        adv_y   = eff_y - ONE;
        adv_dec = eff_dec - b_ext + (dec_pos ? a_ext : DW'(0));
      end
      default: begin
        adv_x   = eff_x + ONE;
        adv_y   = dec_neg ? eff_y - ONE : eff_y;
        adv_dec = eff_dec + a_ext - (dec_neg ? b_ext : DW'(0));
      end
    endcase
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    dec_nxt    = dec_r;
    stop_nxt   = stop_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    oct_nxt    = oct_r;
    color_nxt  = color_r;
    mode_nxt   = mode_r;
    active_nxt = active_r;
    if (emit) begin
      cur_x_nxt  = last ? eff_x   : adv_x;
      cur_y_nxt  = last ? eff_y   : adv_y;
      dec_nxt    = last ? eff_dec : adv_dec;
      stop_nxt   = eff_stop;
      a_nxt      = a_ext[SW-1:0];
      b_nxt      = b_ext[SW-1:0];
      oct_nxt    = eff_oct;
      color_nxt  = eff_color;
      mode_nxt   = eff_mode;
      active_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (adv) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      dec_r   <= dec_nxt;
      stop_r  <= stop_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      oct_r   <= oct_nxt;
      color_r <= color_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // ---------------- output register ----------------
  logic                 out_vld_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [KW-1:0]        out_color_r;
  logic                 out_mode_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r     <= eff_x;
      out_y_r     <= eff_y;
      out_color_r <= eff_color;
      out_mode_r  <= eff_mode;
      out_last_r  <= last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_mode_r, out_color_r, out_y_r, out_x_r});

  // ---------------- checks ----------------
  logic stray_step;
  logic shallow_live;
  assign stray_step   = s2_vld_r && !is_start && !active_r;
  assign shallow_live = active_r && (oct_r == OCT_SHALLOW_UP || oct_r == OCT_SHALLOW_DOWN);

  `MLR_ASSERT_NXT(a_start_emits, clk, rst_n, adv && s2_vld_r && is_start, out_vld_r)
  `MLR_ASSERT_NXT(a_idle_step_silent, clk, rst_n, adv && stray_step, !out_vld_r)
  `MLR_ASSERT_NXT(a_last_ends_line, clk, rst_n, adv && emit && last, !active_r)
  `MLR_ASSERT_IMP(a_shallow_in_range, clk, rst_n, shallow_live, cur_x_r <= stop_r)

endmodule
